// File: sv/tna_pkg.sv
`default_nettype none
package tna_pkg;

  localparam int VertexDepthDefault = 4096;

  localparam int IdxW   = 12;
  localparam int CoordW = 24;
  localparam int EdgeW  = 25;
  localparam int MulW   = 26;
  localparam int ProdW  = 52;
  localparam int CrossW = 51;
  localparam int MagW   = 50;
  localparam int HalfW  = 25;
  localparam int SumW   = 102;
  localparam int RootW  = 51;
  localparam int RemW   = 53;
  localparam int DremW  = 52;
  localparam int QuotW  = 17;
  localparam int NormW  = 16;
  localparam int AreaW  = 49;
  localparam int CntW   = 6;
  localparam int OpW    = 3;

  // datapath step codes
  localparam logic [OpW-1:0] OP_IDLE   = 3'd0;
  localparam logic [OpW-1:0] OP_READ   = 3'd1;
  localparam logic [OpW-1:0] OP_CROSS  = 3'd2;
  localparam logic [OpW-1:0] OP_SQUARE = 3'd3;
  localparam logic [OpW-1:0] OP_SQRT   = 3'd4;
  localparam logic [OpW-1:0] OP_DIV    = 3'd5;
  localparam logic [OpW-1:0] OP_FINISH = 3'd6;

  typedef struct packed {
    logic                     action;
    logic [IdxW-1:0]          vertex_index;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [IdxW-1:0]          corner_a;
    logic [IdxW-1:0]          corner_b;
    logic [IdxW-1:0]          corner_c;
  } req_t;

  typedef struct packed {
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic [AreaW-1:0]        tri_area;
    logic                    degenerate;
  } res_t;

  typedef struct packed {
    logic            capture;
    logic [OpW-1:0]  op;
    logic [CntW-1:0] cnt;
  } ctl_t;

  typedef struct packed {
    logic s_zero;
  } sts_t;

endpackage
`default_nettype wire

// File: sv/tna_ctrl.sv
`default_nettype none
module tna_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic          action,
  input  wire tna_pkg::sts_t sts,
  output logic               busy,
  output tna_pkg::ctl_t      ctl
);
  import tna_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_CROSS  = 3'd2;
  localparam logic [2:0] S_SQUARE = 3'd3;
  localparam logic [2:0] S_CHECK  = 3'd4;
  localparam logic [2:0] S_SQRT   = 3'd5;
  localparam logic [2:0] S_DIV    = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0]      state, state_next;
  logic [CntW-1:0] cnt, cnt_next;
  logic            last;
  logic [OpW-1:0]  op;

  always_comb begin
    state_next = state;
    cnt_next   = cnt + CntW'(1);
    last       = 1'b0;
    op         = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (start && action) state_next = S_READ;
      end
      S_READ: begin
        op   = OP_READ;
        last = (cnt == CntW'(3));
        if (last) state_next = S_CROSS;
      end
      S_CROSS: begin
        op   = OP_CROSS;
        last = (cnt == CntW'(6));
        if (last) state_next = S_SQUARE;
      end
      S_SQUARE: begin
        op   = OP_SQUARE;
        last = (cnt == CntW'(9));
        if (last) state_next = S_CHECK;
      end
      S_CHECK: begin
        last       = 1'b1;
        state_next = sts.s_zero ? S_FINISH : S_SQRT;
      end
      S_SQRT: begin
        op   = OP_SQRT;
        last = (cnt == CntW'(RootW - 1));
        if (last) state_next = S_DIV;
      end
      S_DIV: begin
        op   = OP_DIV;
        last = (cnt == CntW'(QuotW - 1));
        if (last) state_next = S_FINISH;
      end
      S_FINISH: begin
        op         = OP_FINISH;
        last       = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (last) cnt_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  assign busy        = (state != S_IDLE);
  assign ctl.op      = op;
  assign ctl.capture = start && (state == S_IDLE);
  assign ctl.cnt     = cnt;

endmodule
`default_nettype wire

// File: sv/tna_dp.sv
`default_nettype none
module tna_dp #(
  parameter int VERTEX_DEPTH = tna_pkg::VertexDepthDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tna_pkg::req_t request,
  input  wire tna_pkg::ctl_t ctl,
  output tna_pkg::sts_t      sts,
  output tna_pkg::res_t      result,
  output logic               result_valid
);
  import tna_pkg::*;

  localparam int AddrW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int VertW = 3 * CoordW;

  logic [VertW-1:0] mem [VERTEX_DEPTH];

  logic [IdxW-1:0]        corner [3];
  logic [IdxW-1:0]        wr_idx_ext_src, rd_idx;
  logic [AddrW+IdxW-1:0]  wr_ext, rd_ext;
  logic                   wr_ok, rd_ok, rd_oob;
  logic [VertW-1:0]       rdata;
  logic signed [CoordW-1:0] vx [3], vy [3], vz [3];
  logic [1:0]             vsel;
  logic [CntW-1:0]        cnt_m1;

  // vertex store: one write port at request time, one registered read port
  assign wr_idx_ext_src = request.vertex_index;
  assign wr_ext = {AddrW'(0), wr_idx_ext_src};
  assign wr_ok  = (32'(request.vertex_index) < 32'(VERTEX_DEPTH));

  always_comb begin
    case (ctl.cnt[1:0])
      2'd0:    rd_idx = corner[0];
      2'd1:    rd_idx = corner[1];
      default: rd_idx = corner[2];
    endcase
  end
  assign rd_ext = {AddrW'(0), rd_idx};
  assign rd_ok  = (32'(rd_idx) < 32'(VERTEX_DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.capture && !request.action && wr_ok)
      mem[wr_ext[AddrW-1:0]] <= {request.coord_x, request.coord_y, request.coord_z};
    if (ctl.op == OP_READ && ctl.cnt < CntW'(3)) begin
      rdata  <= mem[rd_ext[AddrW-1:0]];
      rd_oob <= !rd_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      corner[0] <= request.corner_a;
      corner[1] <= request.corner_b;
      corner[2] <= request.corner_c;
    end
  end

  assign cnt_m1 = ctl.cnt - CntW'(1);
  assign vsel   = cnt_m1[1:0];

  always_ff @(posedge clk) begin
    if (ctl.op == OP_READ && ctl.cnt != '0) begin
      vx[vsel] <= rd_oob ? '0 : rdata[3*CoordW-1:2*CoordW];
      vy[vsel] <= rd_oob ? '0 : rdata[2*CoordW-1:CoordW];
      vz[vsel] <= rd_oob ? '0 : rdata[CoordW-1:0];
    end
  end

  // edges from corner a
  logic signed [EdgeW-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
  assign e1x = EdgeW'(vx[1]) - EdgeW'(vx[0]);
  assign e1y = EdgeW'(vy[1]) - EdgeW'(vy[0]);
  assign e1z = EdgeW'(vz[1]) - EdgeW'(vz[0]);
  assign e2x = EdgeW'(vx[2]) - EdgeW'(vx[0]);
  assign e2y = EdgeW'(vy[2]) - EdgeW'(vy[0]);
  assign e2z = EdgeW'(vz[2]) - EdgeW'(vz[0]);

  // cross product and magnitudes
  logic signed [CrossW-1:0] xc [3];
  logic [MagW-1:0]          mag [3];
  logic [CrossW-1:0]        neg [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      neg[k] = CrossW'(0) - xc[k];
      mag[k] = xc[k][CrossW-1] ? neg[k][MagW-1:0] : xc[k][MagW-1:0];
    end
  end

  // square index: which component and which partial product
  function automatic logic [3:0] sq_sel(input logic [CntW-1:0] k);
    logic [3:0] r;
    r = 4'd0;
    case (k)
      CntW'(0): r = {2'd0, 2'd0};
      CntW'(1): r = {2'd0, 2'd1};
      CntW'(2): r = {2'd0, 2'd2};
      CntW'(3): r = {2'd1, 2'd0};
      CntW'(4): r = {2'd1, 2'd1};
      CntW'(5): r = {2'd1, 2'd2};
      CntW'(6): r = {2'd2, 2'd0};
      CntW'(7): r = {2'd2, 2'd1};
      CntW'(8): r = {2'd2, 2'd2};
      default:  r = 4'd0;
    endcase
    return r;
  endfunction

  // shared multiplier, product registered
  logic signed [MulW-1:0]  ma, mb;
  logic signed [ProdW-1:0] prod;
  logic [3:0]              iss, acc;
  logic [MagW-1:0]         msq;

  assign iss = sq_sel(ctl.cnt);
  assign acc = sq_sel(cnt_m1);

  always_comb begin
    case (iss[3:2])
      2'd0:    msq = mag[0];
      2'd1:    msq = mag[1];
      default: msq = mag[2];
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    if (ctl.op == OP_CROSS) begin
      case (ctl.cnt)
        CntW'(0): begin ma = MulW'(e1y); mb = MulW'(e2z); end
        CntW'(1): begin ma = MulW'(e1z); mb = MulW'(e2y); end
        CntW'(2): begin ma = MulW'(e1z); mb = MulW'(e2x); end
        CntW'(3): begin ma = MulW'(e1x); mb = MulW'(e2z); end
        CntW'(4): begin ma = MulW'(e1x); mb = MulW'(e2y); end
        CntW'(5): begin ma = MulW'(e1y); mb = MulW'(e2x); end
        default: begin ma = '0; mb = '0; end
      endcase
    end else begin
      case (iss[1:0])
        2'd0:    begin ma = {1'b0, msq[HalfW-1:0]}; mb = {1'b0, msq[HalfW-1:0]}; end
        2'd1:    begin ma = {1'b0, msq[MagW-1:HalfW]}; mb = {1'b0, msq[HalfW-1:0]}; end
        default: begin ma = {1'b0, msq[MagW-1:HalfW]}; mb = {1'b0, msq[MagW-1:HalfW]}; end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  logic signed [CrossW-1:0] prod_c;
  assign prod_c = CrossW'(prod);

  always_ff @(posedge clk) begin
    if (ctl.op == OP_CROSS) begin
      case (ctl.cnt)
        CntW'(1): xc[0] <= prod_c;
        CntW'(2): xc[0] <= xc[0] - prod_c;
        CntW'(3): xc[1] <= prod_c;
        CntW'(4): xc[1] <= xc[1] - prod_c;
        CntW'(5): xc[2] <= prod_c;
        CntW'(6): xc[2] <= xc[2] - prod_c;
        default: ;
      endcase
    end
  end

  // sum of squares from 25-bit partial products
  logic [SumW-1:0] sum, addend;
  always_comb begin
    case (acc[1:0])
      2'd0:    addend = SumW'(prod[MagW-1:0]);
      2'd1:    addend = SumW'(prod[MagW-1:0]) << (HalfW + 1);
      default: addend = SumW'(prod[MagW-1:0]) << (2 * HalfW);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_SQUARE) begin
      if (ctl.cnt == '0) sum <= '0;
      else sum <= sum + addend;
    end
  end

  assign sts.s_zero = (sum == '0);

  // integer square root, one root bit per cycle
  logic [SumW-1:0]  sh, sh_cur;
  logic [RemW-1:0]  rem, rem_cur;
  logic [RootW-1:0] root, root_cur;
  logic [RemW+1:0]  rem_t, trial;

  assign sh_cur   = (ctl.cnt == '0) ? sum : sh;
  assign rem_cur  = (ctl.cnt == '0) ? '0 : rem;
  assign root_cur = (ctl.cnt == '0) ? '0 : root;
  assign rem_t    = {rem_cur, sh_cur[SumW-1:SumW-2]};
  assign trial    = (RemW + 2)'({root_cur, 2'b01});

  always_ff @(posedge clk) begin
    if (ctl.op == OP_SQRT) begin
      sh <= sh_cur << 2;
      if (rem_t >= trial) begin
        rem  <= RemW'(rem_t - trial);
        root <= {root_cur[RootW-2:0], 1'b1};
      end else begin
        rem  <= RemW'(rem_t);
        root <= {root_cur[RootW-2:0], 1'b0};
      end
    end
  end

  // three restoring dividers in step, one quotient bit per cycle
  logic [DremW-1:0]  drem [3];
  logic [QuotW-1:0]  quot [3];
  logic [DremW-1:0]  dnum [3];
  logic [DremW-1:0]  rootx;
  logic              dge  [3];

  assign rootx = DremW'(root);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dnum[k] = (ctl.cnt == '0) ? DremW'(mag[k]) : (drem[k] << 1);
      dge[k]  = (dnum[k] >= rootx);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_DIV) begin
      for (int k = 0; k < 3; k++) begin
        drem[k] <= dge[k] ? (dnum[k] - rootx) : dnum[k];
        quot[k] <= {quot[k][QuotW-2:0], dge[k]};
      end
    end
  end

  // rounding, sign and saturation
  logic [QuotW:0]    qinc [3];
  logic [QuotW-1:0]  mrnd [3];
  logic [QuotW-1:0]  mneg [3];
  logic [NormW-1:0]  nrm  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qinc[k] = (QuotW + 1)'(quot[k]) + (QuotW + 1)'(1);
      mrnd[k] = qinc[k][QuotW:1];
      mneg[k] = QuotW'(0) - mrnd[k];
      if (xc[k][CrossW-1]) nrm[k] = mneg[k][NormW-1:0];
      else if (mrnd[k] > QuotW'(32767)) nrm[k] = NormW'(32767);
      else nrm[k] = mrnd[k][NormW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.op == OP_FINISH) begin
      if (sts.s_zero) begin
        result <= '{normal_x: '0, normal_y: '0, normal_z: '0, tri_area: '0,
                    degenerate: 1'b1};
      end else begin
        result <= '{normal_x: nrm[0], normal_y: nrm[1], normal_z: nrm[2],
                    tri_area: root[AreaW:1], degenerate: 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= (ctl.op == OP_FINISH);
  end

endmodule
`default_nettype wire

// File: sv/triangle_normal_and_area.sv
// channel   ports                        direction  handshake
// request   start, busy, request         in         accepted when start && !busy
// result    result_valid, result         out        one-cycle strobe, no back-pressure
//
// a triangle request walks 4 vertex read steps, 7 cross product
// steps on the shared 26x26 multiplier, 10 square steps, 1 zero check,
// 51 square root steps (one root bit a cycle), 17 divide steps, 1 finish
// a degenerate triangle skips root and divide
// a vertex write completes in the accept cycle and never raises busy
// rst is synchronous; the vertex store is not cleared
// results cannot be stalled; result_valid pulses as busy drops
`default_nettype none
module triangle_normal_and_area #(
  parameter int VERTEX_DEPTH = tna_pkg::VertexDepthDefault
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  output logic               busy,
  input  wire tna_pkg::req_t request,
  output logic               result_valid,
  output tna_pkg::res_t      result
);
  import tna_pkg::*;

  // command and status between sequencer and datapath
  ctl_t ctl;
  sts_t sts;

  // sequencer: walks read, cross, square, check, root, divide and finish phases
  tna_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (request.action),
    .sts    (sts),
    .busy   (busy),
    .ctl    (ctl)
  );

  // datapath: vertex store, shared multiplier, root and divider lanes
  tna_dp #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .request      (request),
    .ctl          (ctl),
    .sts          (sts),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule
`default_nettype wire

// File: sv/tna_checker.sv
`default_nettype none
module tna_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          start,
  input wire logic          busy,
  input wire tna_pkg::req_t request,
  input wire logic          result_valid,
  input wire tna_pkg::res_t result
);
  import tna_pkg::*;

  // a triangle request keeps the block busy
  a_tri_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && request.action |=> busy)
    else $error("triangle request did not raise busy");

  // a vertex write leaves the block free
  a_wr_free: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !request.action |=> !busy)
    else $error("vertex write raised busy");

  // the result strobe is a single pulse when the block frees up
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !busy && $past(busy))
    else $error("result strobe outside completion");

  // a degenerate result carries zero normal and area
  a_degen: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.degenerate |-> result.tri_area == '0 &&
      result.normal_x == '0 && result.normal_y == '0 && result.normal_z == '0)
    else $error("degenerate result not zeroed");

  // after reset nothing is pending
  a_reset: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("state not cleared by reset");

endmodule

bind triangle_normal_and_area tna_checker u_chk (.*);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import tna_pkg::*;

  localparam logic ActWrite = 1'b0;
  localparam logic ActTriangle = 1'b1;
  localparam int CycleLimit = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  req_t request = '0;
  logic result_valid;
  res_t result;

  // model copy of the vertex memory
  logic signed [CoordW-1:0] vert_mem [VertexDepthDefault][3];

  req_t pending_reqs [$];
  res_t expected_faces [$];
  int errors = 0;
  int cycles = 0;
  bit drain_hold = 0;
  bit quiet_stretch = 0;
  logic busy_at_edge = 1'b1;

  triangle_normal_and_area DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .result_valid(result_valid), .result(result)
  );

  always #5 clk = ~clk;

  // appends one request to the pending list
  task automatic queue_req(input req_t rq);
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  // floor(sqrt(s)), one root bit per step
  function automatic logic [RootW-1:0] int_root(logic [SumW-1:0] s);
    logic [RootW-1:0] r;
    logic [RootW-1:0] cand;
    r = '0;
    for (int b = RootW - 1; b >= 0; b--) begin
      cand = r | (51'd1 << b);
      if ({51'd0, cand} * {51'd0, cand} <= s) r = cand;
    end
    return r;
  endfunction

  // q1.15 of c / r with rounding, +1 saturates to 32767
  function automatic logic [NormW-1:0] unit_part(logic signed [CrossW-1:0] c,
                                                 logic [RootW-1:0] r);
    logic [67:0] mag;
    logic [67:0] q;
    logic [67:0] m;
    mag = (c < 0) ? -{{17{c[CrossW-1]}}, c} : {17'd0, c};
    q = (mag << 16) / {17'd0, r};
    m = (q + 1) >> 1;
    if (c < 0) return -m[NormW-1:0];
    if (m > 32767) return 16'sd32767;
    return m[NormW-1:0];
  endfunction

  // applies one request to the model, queues the expected face data
  task automatic predict_face(input req_t rq);
    logic signed [CrossW-1:0] e1 [3];
    logic signed [CrossW-1:0] e2 [3];
    logic signed [CrossW-1:0] xp [3];
    logic [SumW-1:0] s;
    logic [RootW-1:0] r;
    res_t f;
    if (rq.action == ActWrite) begin
      vert_mem[rq.vertex_index][0] = rq.coord_x;
      vert_mem[rq.vertex_index][1] = rq.coord_y;
      vert_mem[rq.vertex_index][2] = rq.coord_z;
      return;
    end
    for (int k = 0; k < 3; k++) begin
      e1[k] = vert_mem[rq.corner_b][k] - vert_mem[rq.corner_a][k];
      e2[k] = vert_mem[rq.corner_c][k] - vert_mem[rq.corner_a][k];
    end
    xp[0] = e1[1] * e2[2] - e1[2] * e2[1];
    xp[1] = e1[2] * e2[0] - e1[0] * e2[2];
    xp[2] = e1[0] * e2[1] - e1[1] * e2[0];
    s = '0;
    for (int k = 0; k < 3; k++)
      s += {{51{xp[k][CrossW-1]}}, xp[k]} * {{51{xp[k][CrossW-1]}}, xp[k]};
    f = '0;
    if (s == 0) begin
      f.degenerate = 1'b1;
    end else begin
      r = int_root(s);
      f.normal_x = unit_part(xp[0], r);
      f.normal_y = unit_part(xp[1], r);
      f.normal_z = unit_part(xp[2], r);
      f.tri_area = r[AreaW:1];
    end
    expected_faces.insert(expected_faces.size(), f);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
  endtask

  function automatic logic signed [CoordW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh7fffff;
      1: return 24'sh800000;
      2: return $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic req_t write_req(int idx, logic signed [CoordW-1:0] x,
                                     logic signed [CoordW-1:0] y,
                                     logic signed [CoordW-1:0] z);
    req_t rq;
    rq = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    rq.action = ActWrite;
    rq.vertex_index = IdxW'(idx);
    rq.coord_x = x;
    rq.coord_y = y;
    rq.coord_z = z;
    return rq;
  endfunction

  function automatic req_t tri_req(int a, int b, int c);
    req_t rq;
    rq = req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
    rq.action = ActTriangle;
    rq.corner_a = IdxW'(a);
    rq.corner_b = IdxW'(b);
    rq.corner_c = IdxW'(c);
    return rq;
  endfunction

  // driver: offers the head request on start until it is taken, idles at random
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_at_edge) begin
        // request was taken at the last rising edge
        void'(pending_reqs.pop_front());
      end
      if (drain_hold && expected_faces.size() == 0) drain_hold <= 1'b0;
      if (pending_reqs.size() > 0 && !drain_hold &&
          (quiet_stretch || $urandom_range(0, 99) >= 15)) begin
        start <= 1'b1;
        request <= pending_reqs[0];
      end else begin
        start <= 1'b0;
        request <= req_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      end
    end
  end

  // accept sampling and monitor at the rising edge
  always @(posedge clk) begin
    res_t want;
    cycles <= cycles + 1;
    busy_at_edge <= busy;
    if (!rst && start && !busy) predict_face(request);
    if (!rst && result_valid) begin
      if (expected_faces.size() == 0) begin
        report_mismatch("unexpected result", 64'(result.tri_area), 64'd0);
      end else begin
        want = expected_faces.pop_front();
        if (result.normal_x !== want.normal_x)
          report_mismatch("normal_x", 64'(result.normal_x), 64'(want.normal_x));
        if (result.normal_y !== want.normal_y)
          report_mismatch("normal_y", 64'(result.normal_y), 64'(want.normal_y));
        if (result.normal_z !== want.normal_z)
          report_mismatch("normal_z", 64'(result.normal_z), 64'(want.normal_z));
        if (result.tri_area !== want.tri_area)
          report_mismatch("tri_area", 64'(result.tri_area), 64'(want.tri_area));
        if (result.degenerate !== want.degenerate)
          report_mismatch("degenerate", 64'(result.degenerate), 64'(want.degenerate));
      end
    end
    if (cycles >= CycleLimit) begin
      $display("timeout at cycle %0d", cycles);
      $display("triangle_normal_and_area regression: fail");
      $finish;
    end
  end

  // stimulus: directed faces first, then random meshes
  initial begin
    int used [$];
    int a, b, c, n;
    // directed: extremes, axis-aligned faces, degenerate cases
    queue_req(write_req(0, 0, 0, 0));
    queue_req(write_req(1, 24'sh010000, 0, 0));
    queue_req(write_req(2, 0, 24'sh010000, 0));
    queue_req(write_req(4095, 24'sh7fffff, 24'sh800000, 24'sh7fffff));
    queue_req(write_req(4094, 24'sh800000, 24'sh7fffff, 24'sh800000));
    queue_req(write_req(3, 24'sh800000, 24'sh800000, 24'sh7fffff));
    queue_req(tri_req(0, 1, 2));     // +z normal saturates
    queue_req(tri_req(0, 2, 1));     // -z normal, -1
    queue_req(tri_req(1, 2, 0));
    queue_req(tri_req(0, 0, 0));     // all corners equal
    queue_req(tri_req(0, 1, 1));     // repeated corner
    queue_req(tri_req(4095, 4094, 3)); // largest edges
    queue_req(tri_req(3, 4095, 4094));
    queue_req(write_req(5, 24'sh020000, 0, 0));
    queue_req(tri_req(0, 1, 5));     // collinear
    queue_req(tri_req(4094, 0, 4095));
    used = '{0, 1, 2, 3, 4094, 4095, 5};
    repeat (4) begin
      queue_req(write_req(used[$urandom_range(0, 6)],
                          rand_coord(), rand_coord(), rand_coord()));
      queue_req(tri_req(used[$urandom_range(0, 6)],
                        used[$urandom_range(0, 6)], used[$urandom_range(0, 6)]));
    end
    #1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    n = pending_reqs.size();
    while (n < 1050) begin
      // no idling while this stretch of requests is fed
      quiet_stretch = (n >= 500 && n < 600);
      if (pending_reqs.size() > 40) begin
        @(posedge clk);
        continue;
      end
      if (n > 700 && n < 705 && !drain_hold) drain_hold = 1;
      if ($urandom_range(0, 99) < 45) begin
        a = $urandom_range(0, 4095);
        queue_req(write_req(a, rand_coord(), rand_coord(), rand_coord()));
        used.insert(used.size(), a);
      end else begin
        a = used[$urandom_range(0, used.size() - 1)];
        b = used[$urandom_range(0, used.size() - 1)];
        c = used[$urandom_range(0, used.size() - 1)];
        queue_req(tri_req(a, b, c));
      end
      n++;
    end
    quiet_stretch = 0;
    wait (pending_reqs.size() == 0);
    wait (expected_faces.size() == 0);
    repeat (120) @(posedge clk);
    if (errors == 0 && expected_faces.size() == 0) begin
      $display("triangle_normal_and_area regression: pass");
    end else begin
      $display("triangle_normal_and_area regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
